[sv/trt_pkg.sv]
// Shared types, sizes and codes for the trace route table.
// No dependencies; every other file imports this package.
package trt_pkg;

    // Table geometry and tag width
    localparam int ROUTE_ENTRIES = 16;
    localparam int PEER_TAG_BITS = 32;
    localparam int IDX_BITS      = (ROUTE_ENTRIES > 1) ? $clog2(ROUTE_ENTRIES) : 1;

    // Result limits
    localparam int RESULT_CAP = 16;
    localparam int CNT_BITS   = $clog2(RESULT_CAP + 1);
    localparam int SLOT_BITS  = 4;

    // Configuration
    localparam int          CFG_INDEX_BITS    = 1;
    localparam logic [0:0]  REG_MY_PEER       = 1'b0;
    localparam logic [0:0]  REG_FUTURE_WINDOW = 1'b1;
    localparam logic [15:0] WINDOW_RESET      = 16'd3600;

    // Input operations
    localparam logic OP_PROBE = 1'b0;
    localparam logic OP_REPLY = 1'b1;

    // Result kinds
    localparam logic [2:0] KIND_ACCEPTED  = 3'd0;
    localparam logic [2:0] KIND_DUPLICATE = 3'd1;
    localparam logic [2:0] KIND_FUTURE    = 3'd2;
    localparam logic [2:0] KIND_FULL      = 3'd3;
    localparam logic [2:0] KIND_CLIENT    = 3'd4;
    localparam logic [2:0] KIND_FORWARD   = 3'd5;
    localparam logic [2:0] KIND_NO_MATCH  = 3'd6;

    typedef logic [PEER_TAG_BITS-1:0] tag_t;
    typedef logic [IDX_BITS-1:0]      idx_t;

    // One table row
    typedef struct packed {
        logic [31:0] stamp;
        tag_t        origin;
        tag_t        ret;
        logic [31:0] prio;
    } entry_t;

    // One result item
    typedef struct packed {
        logic [2:0]  kind;
        logic [3:0]  slot;
        logic        rebroadcast;
        logic [15:0] hops_out;
        logic [31:0] next_peer;
        logic [31:0] prio_out;
        logic [15:0] client_out;
        logic        last;
    } result_t;

    // Table access from the sequencer
    typedef struct packed {
        logic   rd_en;
        idx_t   rd_addr;
        logic   wr_en;
        idx_t   wr_addr;
        entry_t wr_data;
    } mem_req_t;

endpackage

[sv/trt_if.sv]
// Channel interfaces of the trace route table: input items, results, configuration.
// Depends on trt_pkg.
interface trt_req_if;
    import trt_pkg::*;
    logic        valid;
    logic        ready;
    logic        op;
    logic [31:0] stamp;
    logic [31:0] origin_peer;
    logic [31:0] from_peer;
    logic [31:0] prio;
    logic [15:0] hops_left;
    logic [31:0] now;
    logic [15:0] client_slot;

    modport source (output valid, op, stamp, origin_peer, from_peer, prio, hops_left, now,
                    client_slot, input ready);
    modport sink (input valid, op, stamp, origin_peer, from_peer, prio, hops_left, now,
                  client_slot, output ready);
endinterface

interface trt_rsp_if;
    import trt_pkg::*;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [3:0]  slot;
    logic        rebroadcast;
    logic [15:0] hops_out;
    logic [31:0] next_peer;
    logic [31:0] prio_out;
    logic [15:0] client_out;
    logic        last;

    modport source (output valid, kind, slot, rebroadcast, hops_out, next_peer, prio_out,
                    client_out, last, input ready);
    modport sink (input valid, kind, slot, rebroadcast, hops_out, next_peer, prio_out,
                  client_out, last, output ready);
endinterface

interface trt_cfg_if;
    import trt_pkg::*;
    logic                      valid;
    logic                      ready;
    logic [CFG_INDEX_BITS-1:0] index;
    logic [31:0]               data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[sv/trace_route_table.sv]
// Top level of the trace route table: configuration registers, result register,
// sequencer and table RAM. Depends on trt_pkg, trt_if, trt_mem and trt_seq.
//
//   channel  role   payload
//   req      sink   op, stamp, origin_peer, from_peer, prio, hops_left, now, client_slot
//   rsp      source kind, slot, rebroadcast, hops_out, next_peer, prio_out, client_out, last
//   cfg      sink   index, data (0 my_peer, 1 future_window)
//
// One item at a time. Each item is walked with one RAM read per row through the
// single read port, plus capture, drain and the closing result. A reply with several
// matches stalls the walk only when the result register is still full. Reset clears
// the row valid flops, so the table reads as all zero at once; config takes reset
// values.
module trace_route_table (
    input  logic     clk,
    input  logic     rst_n,
    trt_req_if.sink  req,
    trt_rsp_if.source rsp,
    trt_cfg_if.sink  cfg
);
    import trt_pkg::*;

    logic [31:0] my_peer_reg;
    logic [15:0] window_reg;
    logic        out_valid_reg;
    result_t     out_res_reg;

    logic        can_push;
    logic        push;
    result_t     res;
    mem_req_t    mem_req;
    entry_t      rd_data;

    // Configuration writes
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            my_peer_reg <= '0;
            window_reg  <= WINDOW_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_MY_PEER:       my_peer_reg <= cfg.data;
                REG_FUTURE_WINDOW: window_reg  <= cfg.data[15:0];
                default:           my_peer_reg <= my_peer_reg;
            endcase
        end
    end

    // Result register: take a new result when empty or being drained
    assign can_push = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (push)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_res_reg <= res;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.kind        = out_res_reg.kind;
    assign rsp.slot        = out_res_reg.slot;
    assign rsp.rebroadcast = out_res_reg.rebroadcast;
    assign rsp.hops_out    = out_res_reg.hops_out;
    assign rsp.next_peer   = out_res_reg.next_peer;
    assign rsp.prio_out    = out_res_reg.prio_out;
    assign rsp.client_out  = out_res_reg.client_out;
    assign rsp.last        = out_res_reg.last;

    trt_seq u_seq (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req),
        .my_peer       (my_peer_reg),
        .future_window (window_reg),
        .can_push      (can_push),
        .push          (push),
        .res           (res),
        .mem_req       (mem_req),
        .rd_data       (rd_data)
    );

    trt_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // A result is only produced when the result register can take it
    assert property (@(posedge clk) disable iff (!rst_n) push |-> can_push)
        else $error("result pushed into a full result register");

    // The table is written only together with an accepted-probe result
    assert property (@(posedge clk) disable iff (!rst_n)
                     mem_req.wr_en |-> (push && res.kind == KIND_ACCEPTED))
        else $error("table write without an accepted probe");

    // A new item never starts while the previous item's results are incomplete
    assert property (@(posedge clk) disable iff (!rst_n)
                     (req.valid && req.ready) |-> !(rsp.valid && !rsp.last))
        else $error("input transfer while a result sequence is open");

endmodule

[sv/trt_mem.sv]
// Route table storage: one synchronous RAM of entries, registered read.
// Per-row valid flops make unwritten rows read as zero after reset. Depends on trt_pkg.
module trt_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  trt_pkg::mem_req_t req,
    output trt_pkg::entry_t   rd_data
);
    import trt_pkg::*;

    entry_t                   mem [ROUTE_ENTRIES];
    logic [ROUTE_ENTRIES-1:0] row_valid_reg;
    entry_t                   rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Mark rows once written
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
        end
        else if (req.wr_en)
        begin
            row_valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Read port; hold data when no read is issued
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= row_valid_reg[req.rd_addr] ? mem[req.rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[sv/trt_seq.sv]
// Sequencer: captures an item, walks the table one row a cycle when not stalled,
// builds results and writes accepted probes back. Depends on trt_pkg and trt_if.
module trt_seq (
    input  logic              clk,
    input  logic              rst_n,
    trt_req_if.sink           req,
    input  logic [31:0]       my_peer,
    input  logic [15:0]       future_window,
    input  logic              can_push,
    output logic              push,
    output trt_pkg::result_t  res,
    output trt_pkg::mem_req_t mem_req,
    input  trt_pkg::entry_t   rd_data
);
    import trt_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    // Control state
    logic [1:0]          state_reg,      state_next;
    logic                issue_done_reg, issue_done_next;
    logic                chk_valid_reg,  chk_valid_next;
    logic                dup_valid_reg,  dup_valid_next;
    logic                sel_valid_reg,  sel_valid_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [CNT_BITS-1:0] cnt_reg,        cnt_next;

    // Item and scan payload
    logic        op_reg,     op_next;
    logic [31:0] stamp_reg,  stamp_next;
    tag_t        origin_reg, origin_next;
    tag_t        from_reg,   from_next;
    logic [31:0] prio_reg,   prio_next;
    logic [15:0] hops_reg,   hops_next;
    logic [15:0] client_reg, client_next;
    logic        future_reg, future_next;
    idx_t        rd_idx_reg, rd_idx_next;
    idx_t        chk_idx_reg, chk_idx_next;
    idx_t        dup_idx_reg, dup_idx_next;
    idx_t        sel_idx_reg, sel_idx_next;
    logic [31:0] oldest_reg, oldest_next;
    result_t     pend_res_reg, pend_res_next;

    logic    hit;
    logic    older;
    logic    counted;
    logic    stall;
    logic    rd_en;
    tag_t    my_tag;
    result_t match_res;
    result_t done_res;

    assign my_tag    = tag_t'(my_peer);
    assign req.ready = (state_reg == ST_IDLE);

    // Compare the row just read against the held item
    always_comb
    begin
        hit     = (rd_data.stamp == stamp_reg) && (rd_data.origin == origin_reg);
        older   = oldest_reg > rd_data.stamp;
        counted = hit && (cnt_reg < CNT_BITS'(RESULT_CAP));
        stall   = (state_reg == ST_SCAN) && chk_valid_reg && (op_reg == OP_REPLY)
                  && counted && pend_valid_reg && !can_push;

        match_res      = '0;
        match_res.slot = SLOT_BITS'(chk_idx_reg);
        if (rd_data.ret == my_tag)
        begin
            match_res.kind       = KIND_CLIENT;
            match_res.client_out = client_reg;
        end
        else
        begin
            match_res.kind      = KIND_FORWARD;
            match_res.next_peer = 32'(rd_data.ret);
            match_res.prio_out  = rd_data.prio;
        end
    end

    // Final result of an item
    always_comb
    begin
        done_res      = '0;
        done_res.last = 1'b1;
        if (op_reg == OP_REPLY)
        begin
            if (pend_valid_reg)
            begin
                done_res      = pend_res_reg;
                done_res.last = 1'b1;
            end
            else
            begin
                done_res.kind = KIND_NO_MATCH;
            end
        end
        else if (future_reg)
        begin
            done_res.kind = KIND_FUTURE;
        end
        else if (dup_valid_reg)
        begin
            done_res.kind = KIND_DUPLICATE;
            done_res.slot = SLOT_BITS'(dup_idx_reg);
        end
        else if (!sel_valid_reg)
        begin
            done_res.kind = KIND_FULL;
        end
        else
        begin
            done_res.kind = KIND_ACCEPTED;
            done_res.slot = SLOT_BITS'(sel_idx_reg);
            if (hops_reg != 16'd0)
            begin
                done_res.rebroadcast = 1'b1;
                done_res.hops_out    = hops_reg - 16'd1;
            end
        end
    end

    // Sequencer next state
    always_comb
    begin
        state_next      = state_reg;
        issue_done_next = issue_done_reg;
        chk_valid_next  = chk_valid_reg;
        dup_valid_next  = dup_valid_reg;
        sel_valid_next  = sel_valid_reg;
        pend_valid_next = pend_valid_reg;
        cnt_next        = cnt_reg;
        op_next         = op_reg;
        stamp_next      = stamp_reg;
        origin_next     = origin_reg;
        from_next       = from_reg;
        prio_next       = prio_reg;
        hops_next       = hops_reg;
        client_next     = client_reg;
        future_next     = future_reg;
        rd_idx_next     = rd_idx_reg;
        chk_idx_next    = chk_idx_reg;
        dup_idx_next    = dup_idx_reg;
        sel_idx_next    = sel_idx_reg;
        oldest_next     = oldest_reg;
        pend_res_next   = pend_res_reg;

        rd_en           = 1'b0;
        push            = 1'b0;
        res             = pend_res_reg;
        mem_req         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                // Capture the item on transfer
                if (req.valid)
                begin
                    op_next         = req.op;
                    stamp_next      = req.stamp;
                    origin_next     = tag_t'(req.origin_peer);
                    from_next       = tag_t'(req.from_peer);
                    prio_next       = req.prio;
                    hops_next       = req.hops_left;
                    client_next     = req.client_slot;
                    future_next     = {1'b0, req.stamp} >
                                      ({1'b0, req.now} + {17'd0, future_window});
                    oldest_next     = req.stamp;
                    rd_idx_next     = '0;
                    issue_done_next = 1'b0;
                    chk_valid_next  = 1'b0;
                    dup_valid_next  = 1'b0;
                    sel_valid_next  = 1'b0;
                    pend_valid_next = 1'b0;
                    cnt_next        = '0;
                    state_next      = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (!stall)
                begin
                    // Issue the next row read
                    rd_en = !issue_done_reg;
                    if (rd_en)
                    begin
                        rd_idx_next = rd_idx_reg + idx_t'(1);
                        if (rd_idx_reg == idx_t'(ROUTE_ENTRIES - 1))
                        begin
                            issue_done_next = 1'b1;
                        end
                    end
                    chk_valid_next = rd_en;
                    chk_idx_next   = rd_idx_reg;

                    // Check the row that came back
                    if (chk_valid_reg)
                    begin
                        if (op_reg == OP_PROBE)
                        begin
                            if (hit && !dup_valid_reg)
                            begin
                                dup_valid_next = 1'b1;
                                dup_idx_next   = chk_idx_reg;
                            end
                            if (older)
                            begin
                                oldest_next    = rd_data.stamp;
                                sel_idx_next   = chk_idx_reg;
                                sel_valid_next = 1'b1;
                            end
                        end
                        else if (counted)
                        begin
                            // Release the previous match, hold the new one
                            push            = pend_valid_reg;
                            res             = pend_res_reg;
                            pend_res_next   = match_res;
                            pend_valid_next = 1'b1;
                            cnt_next        = cnt_reg + CNT_BITS'(1);
                        end
                    end

                    if (issue_done_reg && !chk_valid_reg)
                    begin
                        state_next = ST_DONE;
                    end
                end
            end
            ST_DONE:
            begin
                // Emit the closing result; write back an accepted probe with it
                if (can_push)
                begin
                    push       = 1'b1;
                    res        = done_res;
                    mem_req.wr_en = (op_reg == OP_PROBE) && (done_res.kind == KIND_ACCEPTED);
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        mem_req.rd_en   = rd_en;
        mem_req.rd_addr = rd_idx_reg;
        mem_req.wr_addr = sel_idx_reg;
        mem_req.wr_data = '{stamp: stamp_reg, origin: origin_reg, ret: from_reg,
                            prio: prio_reg};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            issue_done_reg <= 1'b0;
            chk_valid_reg  <= 1'b0;
            dup_valid_reg  <= 1'b0;
            sel_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            cnt_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            issue_done_reg <= issue_done_next;
            chk_valid_reg  <= chk_valid_next;
            dup_valid_reg  <= dup_valid_next;
            sel_valid_reg  <= sel_valid_next;
            pend_valid_reg <= pend_valid_next;
            cnt_reg        <= cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        stamp_reg    <= stamp_next;
        origin_reg   <= origin_next;
        from_reg     <= from_next;
        prio_reg     <= prio_next;
        hops_reg     <= hops_next;
        client_reg   <= client_next;
        future_reg   <= future_next;
        rd_idx_reg   <= rd_idx_next;
        chk_idx_reg  <= chk_idx_next;
        dup_idx_reg  <= dup_idx_next;
        sel_idx_reg  <= sel_idx_next;
        oldest_reg   <= oldest_next;
        pend_res_reg <= pend_res_next;
    end

endmodule
